[rtl/core/csa_pkg.sv]
// Types and codes shared by the contiguous slot allocator modules.
`default_nettype none

package csa_pkg;

	// request function codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_NEXT  = 2'd1,
		POL_BEST  = 2'd2,
		POL_WORST = 2'd3
	} policy_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_MARK,
		ST_FREE
	} state_t;

	typedef struct packed {
		logic       func;
		logic [6:0] run_length;
		logic [5:0] free_start;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic [5:0] start_slot;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // latch request, set up scan
		logic step;     // examine one slot
		logic wrap;     // restart scan at slot 0
		logic commit;   // mark chosen run, report
		logic free_op;  // clear range, report
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic    func;
		logic    len_zero;
		policy_t policy;
		logic    hit;        // run of full length ends at current slot
		logic    last_slot;  // counter on the last slot
		logic    at_end;     // counter one past the last slot
	} stat_t;

endpackage

`default_nettype wire

[rtl/core/csa_dp.sv]
// Datapath: occupancy map, roving position, scan counter, gap tracking, result registers.
`default_nettype none

module csa_dp #(
	parameter int SLOTS = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  csa_pkg::req_t       req,
	input  csa_pkg::cmd_t       cmd,
	input  wire                 cfg_we,
	input  wire  [1:0]          cfg_data,
	output csa_pkg::stat_t      stat,
	output logic                done,
	output csa_pkg::rsp_t       rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = ((IW > 7) ? IW : 7) + 1;

	logic [SLOTS-1:0]  map_q;
	logic [IW-1:0]     rov_q;
	csa_pkg::policy_t  policy_q;
	logic              func_q;
	logic [6:0]        len_q;
	logic [5:0]        fstart_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     run_q;
	logic [IW-1:0]     begin_q;
	logic [IW-1:0]     pick_q;
	logic [CW-1:0]     pick_size_q;
	logic              pick_valid_q;
	logic              done_q;
	logic              granted_q;
	logic [5:0]        start_q;

	logic              in_map;
	logic              slot_free;
	logic [CW-1:0]     run_inc;
	logic [EW-1:0]     len_ext;
	logic              hit;
	logic [EW-1:0]     hit_start_ext;
	logic              gap_mode;
	logic              gap_ok;
	logic              better;
	logic [EW-1:0]     pick_ext;
	logic [EW-1:0]     pick_end;
	logic [EW-1:0]     fstart_ext;
	logic [EW-1:0]     free_end;
	logic [SLOTS-1:0]  mask_alloc;
	logic [SLOTS-1:0]  mask_free;

	assign in_map    = cnt_q < CW'(SLOTS);
	assign slot_free = in_map && !map_q[cnt_q[IW-1:0]];
	assign run_inc   = run_q + CW'(1);
	assign len_ext   = EW'(len_q);
	assign hit       = slot_free && (EW'(run_inc) == len_ext);
	assign hit_start_ext = EW'(cnt_q) + EW'(1) - len_ext;

	assign gap_mode = (policy_q == csa_pkg::POL_BEST) || (policy_q == csa_pkg::POL_WORST);
	assign gap_ok   = EW'(run_q) >= len_ext;
	assign better   = !pick_valid_q ||
		((policy_q == csa_pkg::POL_WORST) ? (run_q > pick_size_q) : (run_q < pick_size_q));

	assign pick_ext   = EW'(pick_q);
	assign pick_end   = pick_ext + len_ext;
	assign fstart_ext = EW'(fstart_q);
	assign free_end   = fstart_ext + len_ext;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			mask_alloc[i] = (EW'(i) >= pick_ext) && (EW'(i) < pick_end);
			mask_free[i]  = (EW'(i) >= fstart_ext) && (EW'(i) < free_end);
		end
	end

	assign stat.func      = func_q;
	assign stat.len_zero  = (len_q == 7'd0);
	assign stat.policy    = policy_q;
	assign stat.hit       = hit;
	assign stat.last_slot = (cnt_q == CW'(SLOTS - 1));
	assign stat.at_end    = (cnt_q == CW'(SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q        <= '0;
			rov_q        <= '0;
			policy_q     <= csa_pkg::POL_FIRST;
			cnt_q        <= '0;
			run_q        <= '0;
			pick_valid_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				policy_q <= csa_pkg::policy_t'(cfg_data);
			end
			if (cmd.load) begin
				cnt_q        <= (policy_q == csa_pkg::POL_NEXT) ? CW'(rov_q) : '0;
				run_q        <= '0;
				pick_valid_q <= 1'b0;
			end
			if (cmd.step) begin
				cnt_q <= cnt_q + CW'(1);
				if (slot_free) begin
					run_q <= run_inc;
				end else begin
					run_q <= '0;
					if (gap_mode && gap_ok && better) begin
						pick_valid_q <= 1'b1;
					end
				end
				if (!gap_mode && hit) begin
					pick_valid_q <= 1'b1;
				end
			end
			if (cmd.wrap) begin
				cnt_q <= '0;
				run_q <= '0;
			end
			if (cmd.commit) begin
				done_q <= 1'b1;
				if (pick_valid_q) begin
					map_q <= map_q | mask_alloc;
					if (policy_q == csa_pkg::POL_NEXT) begin
						rov_q <= (pick_end >= EW'(SLOTS)) ? '0 : pick_end[IW-1:0];
					end
				end
			end
			if (cmd.free_op) begin
				done_q <= 1'b1;
				map_q  <= map_q & ~mask_free;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= req.func;
			len_q    <= req.run_length;
			fstart_q <= req.free_start;
		end
		if (cmd.step) begin
			if (slot_free && (run_q == '0)) begin
				begin_q <= cnt_q[IW-1:0];
			end
			if (!slot_free && gap_mode && gap_ok && better) begin
				pick_q      <= begin_q;
				pick_size_q <= run_q;
			end
			if (!gap_mode && hit) begin
				pick_q <= hit_start_ext[IW-1:0];
			end
		end
		if (cmd.commit) begin
			granted_q <= pick_valid_q;
			start_q   <= pick_valid_q ? pick_ext[5:0] : 6'd0;
		end
		if (cmd.free_op) begin
			granted_q <= 1'b1;
			start_q   <= fstart_q;
		end
	end

	assign done           = done_q;
	assign rsp.granted    = granted_q;
	assign rsp.start_slot = start_q;

	a_report_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.commit || cmd.free_op))
		else $error("result without commit or free");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !pick_valid_q) |=> (done_q && !granted_q && (start_q == 6'd0)))
		else $error("refused allocation not reported as zero");

	a_free_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free_op |=> (done_q && granted_q))
		else $error("free not reported as done");

endmodule

`default_nettype wire

[rtl/core/csa_ctrl.sv]
// Controller: sequences load, slot scan, wrap pass, commit and free.
`default_nettype none

module csa_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  csa_pkg::stat_t     stat,
	output logic               busy,
	output csa_pkg::cmd_t      cmd
);

	csa_pkg::state_t state_q, state_d;
	logic            wrap_q;
	logic            gap_mode;

	assign gap_mode = (stat.policy == csa_pkg::POL_BEST) || (stat.policy == csa_pkg::POL_WORST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csa_pkg::ST_IDLE;
			wrap_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				wrap_q <= 1'b0;
			end else if (cmd.wrap) begin
				wrap_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			csa_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = csa_pkg::ST_DECIDE;
				end
			end
			csa_pkg::ST_DECIDE: begin
				priority if (stat.func == csa_pkg::FUNC_FREE) begin
					state_d = csa_pkg::ST_FREE;
				end else if (stat.len_zero) begin
					state_d = csa_pkg::ST_MARK;
				end else begin
					state_d = csa_pkg::ST_SCAN;
				end
			end
			csa_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (gap_mode) begin
					if (stat.at_end) begin
						state_d = csa_pkg::ST_MARK;
					end
				end else begin
					priority if (stat.hit) begin
						state_d = csa_pkg::ST_MARK;
					end else if (stat.last_slot) begin
						if (stat.policy == csa_pkg::POL_NEXT && !wrap_q) begin
							cmd.wrap = 1'b1;
						end else begin
							state_d = csa_pkg::ST_MARK;
						end
					end else begin
						state_d = csa_pkg::ST_SCAN;
					end
				end
			end
			csa_pkg::ST_MARK: begin
				cmd.commit = 1'b1;
				state_d    = csa_pkg::ST_IDLE;
			end
			csa_pkg::ST_FREE: begin
				cmd.free_op = 1'b1;
				state_d     = csa_pkg::ST_IDLE;
			end
			default: begin
				state_d = csa_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != csa_pkg::ST_IDLE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_one_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_q |-> !cmd.wrap)
		else $error("second wrap pass in one request");

	a_report_once: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.free_op) |=> (state_q == csa_pkg::ST_IDLE))
		else $error("controller did not return to idle after report");

endmodule

`default_nettype wire

[rtl/core/contiguous_slot_allocator_top.sv]
// Top level of the contiguous slot allocator (first, next, best and worst fit).
//
//  channel   signals                         direction  handshake
//  --------  ------------------------------  ---------  ------------------------------
//  request   start, busy, req                in         beat taken when start & !busy
//  result    done, rsp                       out        one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data  in         beat taken when cfg_valid & cfg_ready
//
// Sequence: load, decode, scan, commit (a zero length skips the scan); the result
//   strobe follows the commit. First fit scans to a hit or the last slot, next fit
//   from the roving position, then a pass from slot 0, best/worst fit to one past
//   the last slot. A free: load, decode, free. The scan examines one map bit per cycle.
// Reset: arst_n clears the map (all slots free), roving position and policy.
// Stalls: busy holds off requests; results cannot be held, the output
//   register lets a new request enter during the strobe cycle.
`default_nettype none

module contiguous_slot_allocator_top #(
	parameter int SLOTS = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  csa_pkg::req_t     req,
	output logic              done,
	output csa_pkg::rsp_t     rsp,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [1:0]        cfg_data
);

	csa_pkg::cmd_t  cmd;
	csa_pkg::stat_t stat;
	logic           cfg_we;

	// policy may change only between requests, never on the edge that takes one
	assign cfg_ready = !busy && !start;
	assign cfg_we    = cfg_valid && cfg_ready;

	csa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	csa_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.stat     (stat),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire
